// ===== src/tlik_pkg.sv =====
// Shared types, widths, constants and command codes for the two-link arm kinematics core.
// Used by the controller, the datapath and the top level; depends on nothing else.
package tlik_pkg;

    localparam int ANG_W   = 16;
    localparam int LEN_W   = 23;
    localparam int POS_W   = 24;
    localparam int CFG_W   = 23;
    localparam int CFG_IDX_W = 3;
    localparam int T_W     = 21;
    localparam int CS_W    = 18;
    localparam int CX_W    = 19;
    localparam int CZ_W    = 20;
    localparam int OPA_W   = 24;
    localparam int OPB_W   = 18;
    localparam int P_W     = 42;
    localparam int MOP_W   = 43;
    localparam int LO_W    = 22;
    localparam int ACC_W   = 60;
    localparam int PX_W    = 26;
    localparam int Q_W     = 13;
    localparam int D_W     = 14;
    localparam int DM_W    = 27;
    localparam int IDX_W   = 4;

    localparam int ANG_2PI      = 51472;
    localparam int ANG_PI       = 25736;
    localparam int PI_Q16       = 205888;
    localparam int HALF_PI_Q16  = 102944;
    localparam int CORDIC_GAIN  = 39797;
    localparam int CORDIC_LAST  = 15;
    localparam int STEP_LIMIT   = 4096;
    localparam int DAMP_Q13     = 7373;
    localparam int DAMP_RND     = 4096;
    localparam int DAMP_SHIFT   = 13;
    localparam int POSE_RND     = 32768;
    localparam int POSE_SHIFT   = 16;
    localparam int DX_SHIFT     = 29;
    localparam int DIV_TOP      = 12;
    localparam int NEWTON_STEPS_DEF = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LINK1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_J1OFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOFF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_J2OFF = 3'd4;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NOP         = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD        = 5'd1;
    localparam logic [OP_W-1:0] OP_INIT_T      = 5'd2;
    localparam logic [OP_W-1:0] OP_WRAP_T1     = 5'd3;
    localparam logic [OP_W-1:0] OP_WRAP_SUM    = 5'd4;
    localparam logic [OP_W-1:0] OP_WRAP_STEP   = 5'd5;
    localparam logic [OP_W-1:0] OP_CORDIC_INIT = 5'd6;
    localparam logic [OP_W-1:0] OP_CORDIC_STEP = 5'd7;
    localparam logic [OP_W-1:0] OP_STORE_CS1   = 5'd8;
    localparam logic [OP_W-1:0] OP_STORE_CS12  = 5'd9;
    localparam logic [OP_W-1:0] OP_PX_STORE    = 5'd10;
    localparam logic [OP_W-1:0] OP_PY_STORE    = 5'd11;
    localparam logic [OP_W-1:0] OP_DEN_STORE   = 5'd12;
    localparam logic [OP_W-1:0] OP_L2S_STORE   = 5'd13;
    localparam logic [OP_W-1:0] OP_SET_SING    = 5'd14;
    localparam logic [OP_W-1:0] OP_PREP        = 5'd15;
    localparam logic [OP_W-1:0] OP_N0_STORE    = 5'd16;
    localparam logic [OP_W-1:0] OP_N1_STORE    = 5'd17;
    localparam logic [OP_W-1:0] OP_DIV_INIT    = 5'd18;
    localparam logic [OP_W-1:0] OP_DIV_STEP    = 5'd19;
    localparam logic [OP_W-1:0] OP_DIV_DONE    = 5'd20;
    localparam logic [OP_W-1:0] OP_SAVE        = 5'd21;
    localparam logic [OP_W-1:0] OP_OUT_LOAD    = 5'd22;

    localparam logic [2:0] MUL_L2C12 = 3'd0;
    localparam logic [2:0] MUL_L1C1  = 3'd1;
    localparam logic [2:0] MUL_L2S12 = 3'd2;
    localparam logic [2:0] MUL_L1S1  = 3'd3;
    localparam logic [2:0] MUL_LO    = 3'd4;
    localparam logic [2:0] MUL_HI    = 3'd5;

    localparam logic [1:0] ACC_NONE     = 2'd0;
    localparam logic [1:0] ACC_LOAD_RND = 2'd1;
    localparam logic [1:0] ACC_ADD      = 2'd2;
    localparam logic [1:0] ACC_ADD_HI   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [2:0]       mul_sel;
        logic [1:0]       acc_op;
        logic [IDX_W-1:0] idx;
    } tlik_cmd_t;

    typedef struct packed {
        logic wrap_ok;
        logic den_zero;
    } tlik_status_t;

    function automatic logic signed [CZ_W-1:0] atan_q16(input logic [IDX_W-1:0] i);
        logic signed [CZ_W-1:0] r;
        unique case (i)
            4'd0:    r = 20'sd51472;
            4'd1:    r = 20'sd30385;
            4'd2:    r = 20'sd16055;
            4'd3:    r = 20'sd8150;
            4'd4:    r = 20'sd4091;
            4'd5:    r = 20'sd2047;
            4'd6:    r = 20'sd1024;
            4'd7:    r = 20'sd512;
            4'd8:    r = 20'sd256;
            4'd9:    r = 20'sd128;
            4'd10:   r = 20'sd64;
            4'd11:   r = 20'sd32;
            4'd12:   r = 20'sd16;
            4'd13:   r = 20'sd8;
            4'd14:   r = 20'sd4;
            default: r = 20'sd2;
        endcase
        return r;
    endfunction

endpackage

// ===== src/tlik_dp.sv =====
// Datapath of the two-link arm kinematics core: configuration, joint state, CORDIC,
// shared multiplier with accumulator, restoring divider and output word. Uses tlik_pkg.
module tlik_dp
    import tlik_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tlik_cmd_t                   cmd,
    output tlik_status_t                status,
    input  logic                        s_kind,
    input  logic signed [POS_W-1:0]     s_target_x,
    input  logic signed [ANG_W-1:0]     s_target_angle,
    input  logic signed [ANG_W-1:0]     s_load_angle_one,
    input  logic signed [ANG_W-1:0]     s_load_angle_two,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    output logic signed [ANG_W-1:0]     m_angle_one,
    output logic signed [ANG_W-1:0]     m_angle_two,
    output logic signed [POS_W-1:0]     m_tool_x,
    output logic signed [POS_W-1:0]     m_tool_y,
    output logic signed [ANG_W-1:0]     m_tool_angle,
    output logic                        m_singular
);

    logic [LEN_W-1:0]          link1_reg, link2_reg;
    logic signed [ANG_W-1:0]   j1off_reg, toff_reg, j2off_reg;
    logic signed [ANG_W-1:0]   ja_reg, jb_reg;
    logic signed [POS_W-1:0]   tx_reg;
    logic signed [ANG_W-1:0]   tphi_reg;
    logic                      sing_reg;
    logic signed [T_W-1:0]     t1_reg, t2_reg, w_reg;
    logic signed [CX_W-1:0]    cx_reg, cy_reg;
    logic signed [CZ_W-1:0]    cz_reg;
    logic                      flip_reg;
    logic signed [CS_W-1:0]    c1_reg, s1_reg, c12_reg, s12_reg;
    logic signed [ANG_W-1:0]   wsum_reg;
    logic signed [P_W-1:0]     prod_reg, den_reg, l2s_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next, num0_reg, num1_reg;
    logic signed [MOP_W-1:0]   mop_reg;
    logic signed [OPB_W-1:0]   dphi_reg;
    logic signed [PX_W-1:0]    px_reg, py_reg;
    logic [ACC_W-1:0]          rem_reg;
    logic [P_W-1:0]            dabs_reg;
    logic [Q_W-1:0]            q_reg;
    logic                      neg_reg, big_reg;

    logic signed [ANG_W:0]     off2;
    logic signed [OPA_W-1:0]   mul_a;
    logic signed [OPB_W-1:0]   mul_b;
    logic signed [P_W-1:0]     prod_next;
    logic signed [PX_W:0]      dx_diff;
    logic signed [ACC_W-1:0]   dx;
    logic signed [CZ_W-1:0]    z0;
    logic signed [CX_W-1:0]    sh_x, sh_y;
    logic signed [ACC_W-1:0]   num_sel;
    logic [ACC_W-1:0]          nabs, dsub;
    logic [P_W-1:0]            dabs;
    logic [Q_W-1:0]            qc;
    logic signed [D_W-1:0]     dstep;
    logic signed [DM_W-1:0]    dmul;
    logic signed [D_W-1:0]     tstep;
    logic signed [T_W:0]       ja_raw, jb_raw;

    function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [T_W:0] v);
        logic signed [ANG_W-1:0] r;
        if (v > 32767) begin
            r = 16'sh7fff;
        end else if (v < -32768) begin
            r = 16'sh8000;
        end else begin
            r = v[ANG_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PX_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 8388607) begin
            r = 24'sh7fffff;
        end else if (v < -8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    assign off2 = (ANG_W+1)'(toff_reg) + (ANG_W+1)'(j2off_reg);

    assign status.wrap_ok  = !(w_reg > ANG_PI) && !(w_reg <= -ANG_PI);
    assign status.den_zero = (den_reg == '0);

    always_comb begin
        unique case (cmd.mul_sel)
            MUL_L2C12: begin mul_a = signed'({1'b0, link2_reg}); mul_b = c12_reg; end
            MUL_L1C1:  begin mul_a = signed'({1'b0, link1_reg}); mul_b = c1_reg;  end
            MUL_L2S12: begin mul_a = signed'({1'b0, link2_reg}); mul_b = s12_reg; end
            MUL_L1S1:  begin mul_a = signed'({1'b0, link1_reg}); mul_b = s1_reg;  end
            MUL_LO: begin
                mul_a = signed'({2'b00, mop_reg[LO_W-1:0]});
                mul_b = dphi_reg;
            end
            default: begin
                mul_a = OPA_W'(signed'(mop_reg[MOP_W-1:LO_W]));
                mul_b = dphi_reg;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    assign dx_diff = (PX_W+1)'(tx_reg) - (PX_W+1)'(px_reg);
    assign dx      = ACC_W'(dx_diff) <<< DX_SHIFT;

    always_comb begin
        acc_next = acc_reg;
        unique case (cmd.acc_op)
            ACC_LOAD_RND: acc_next = ACC_W'(prod_reg) + ACC_W'(POSE_RND);
            ACC_ADD:      acc_next = acc_reg + ACC_W'(prod_reg);
            ACC_ADD_HI:   acc_next = acc_reg + (ACC_W'(prod_reg) <<< LO_W);
            default:      acc_next = acc_reg;
        endcase
        if (cmd.op == OP_PREP || cmd.op == OP_N0_STORE) begin
            acc_next = dx;
        end
    end

    assign z0   = {w_reg[CZ_W-4:0], 3'b000};
    assign sh_x = cx_reg >>> cmd.idx;
    assign sh_y = cy_reg >>> cmd.idx;

    assign num_sel = cmd.idx[0] ? num1_reg : num0_reg;
    assign nabs    = num_sel[ACC_W-1] ? ACC_W'(-num_sel) : ACC_W'(num_sel);
    assign dabs    = den_reg[P_W-1] ? P_W'(-den_reg) : P_W'(den_reg);
    assign dsub    = ACC_W'(dabs_reg) << cmd.idx;

    assign qc    = (big_reg || q_reg > Q_W'(STEP_LIMIT)) ? Q_W'(STEP_LIMIT) : q_reg;
    assign dstep = neg_reg ? -D_W'(qc) : D_W'(qc);
    assign dmul  = DM_W'(dstep) * DM_W'(DAMP_Q13) + DM_W'(DAMP_RND);
    assign tstep = dmul[DM_W-1:DAMP_SHIFT];

    assign ja_raw = (T_W+1)'(t1_reg) - (T_W+1)'(j1off_reg);
    assign jb_raw = (T_W+1)'(t2_reg) - (T_W+1)'(off2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link1_reg <= '0;
            link2_reg <= '0;
            j1off_reg <= '0;
            toff_reg  <= '0;
            j2off_reg <= '0;
            ja_reg    <= '0;
            jb_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_LINK1: link1_reg <= cfg_data;
                    CFG_LINK2: link2_reg <= cfg_data;
                    CFG_J1OFF: j1off_reg <= cfg_data[ANG_W-1:0];
                    CFG_TOFF:  toff_reg  <= cfg_data[ANG_W-1:0];
                    CFG_J2OFF: j2off_reg <= cfg_data[ANG_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.op == OP_LOAD && s_kind) begin
                ja_reg <= s_load_angle_one;
                jb_reg <= s_load_angle_two;
            end else if (cmd.op == OP_SAVE) begin
                ja_reg <= sat_ang(ja_raw);
                jb_reg <= sat_ang(jb_raw);
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        unique case (cmd.op)
            OP_LOAD: begin
                tx_reg   <= s_target_x;
                tphi_reg <= s_target_angle;
                sing_reg <= 1'b0;
            end
            OP_INIT_T: begin
                t1_reg <= T_W'(ja_reg) + T_W'(j1off_reg);
                t2_reg <= T_W'(jb_reg) + T_W'(off2);
            end
            OP_WRAP_T1:  w_reg <= t1_reg;
            OP_WRAP_SUM: w_reg <= t1_reg + t2_reg;
            OP_WRAP_STEP: begin
                if (w_reg > ANG_PI) begin
                    w_reg <= w_reg - T_W'(ANG_2PI);
                end else if (w_reg <= -ANG_PI) begin
                    w_reg <= w_reg + T_W'(ANG_2PI);
                end
            end
            OP_CORDIC_INIT: begin
                cx_reg <= CX_W'(CORDIC_GAIN);
                cy_reg <= '0;
                if (z0 > HALF_PI_Q16) begin
                    cz_reg   <= z0 - CZ_W'(PI_Q16);
                    flip_reg <= 1'b1;
                end else if (z0 < -HALF_PI_Q16) begin
                    cz_reg   <= z0 + CZ_W'(PI_Q16);
                    flip_reg <= 1'b1;
                end else begin
                    cz_reg   <= z0;
                    flip_reg <= 1'b0;
                end
            end
            OP_CORDIC_STEP: begin
                if (!cz_reg[CZ_W-1]) begin
                    cx_reg <= cx_reg - sh_y;
                    cy_reg <= cy_reg + sh_x;
                    cz_reg <= cz_reg - atan_q16(cmd.idx);
                end else begin
                    cx_reg <= cx_reg + sh_y;
                    cy_reg <= cy_reg - sh_x;
                    cz_reg <= cz_reg + atan_q16(cmd.idx);
                end
            end
            OP_STORE_CS1: begin
                c1_reg <= flip_reg ? CS_W'(-cx_reg) : CS_W'(cx_reg);
                s1_reg <= flip_reg ? CS_W'(-cy_reg) : CS_W'(cy_reg);
            end
            OP_STORE_CS12: begin
                c12_reg  <= flip_reg ? CS_W'(-cx_reg) : CS_W'(cx_reg);
                s12_reg  <= flip_reg ? CS_W'(-cy_reg) : CS_W'(cy_reg);
                wsum_reg <= w_reg[ANG_W-1:0];
            end
            OP_PX_STORE:  px_reg  <= PX_W'(acc_reg >>> POSE_SHIFT);
            OP_PY_STORE:  py_reg  <= PX_W'(acc_reg >>> POSE_SHIFT);
            OP_DEN_STORE: den_reg <= prod_reg;
            OP_L2S_STORE: l2s_reg <= prod_reg;
            OP_SET_SING:  sing_reg <= 1'b1;
            OP_PREP: begin
                dphi_reg <= OPB_W'(tphi_reg) - OPB_W'(wsum_reg);
                mop_reg  <= MOP_W'(l2s_reg);
            end
            OP_N0_STORE: begin
                num0_reg <= -acc_reg;
                mop_reg  <= MOP_W'(den_reg) + MOP_W'(l2s_reg);
            end
            OP_N1_STORE: num1_reg <= acc_reg;
            OP_DIV_INIT: begin
                rem_reg  <= nabs;
                dabs_reg <= dabs;
                neg_reg  <= num_sel[ACC_W-1] ^ den_reg[P_W-1];
                big_reg  <= nabs >= (ACC_W'(dabs) << Q_W);
                q_reg    <= '0;
            end
            OP_DIV_STEP: begin
                if (rem_reg >= dsub) begin
                    rem_reg <= rem_reg - dsub;
                    q_reg   <= q_reg | (Q_W'(1) << cmd.idx);
                end
            end
            OP_DIV_DONE: begin
                if (cmd.idx[0]) begin
                    t2_reg <= t2_reg + T_W'(tstep);
                end else begin
                    t1_reg <= t1_reg + T_W'(tstep);
                end
            end
            OP_OUT_LOAD: begin
                m_angle_one  <= ja_reg;
                m_angle_two  <= jb_reg;
                m_tool_x     <= sat_pos(px_reg);
                m_tool_y     <= sat_pos(py_reg);
                m_tool_angle <= wsum_reg;
                m_singular   <= sing_reg;
            end
            default: ;
        endcase
    end

endmodule

// ===== src/tlik_ctrl.sv =====
// Controller of the two-link arm kinematics core: sequences wrap, CORDIC, multiply,
// divide and Newton iterations, and owns both handshakes. Uses tlik_pkg.
module tlik_ctrl
    import tlik_pkg::*;
#(
    parameter int NEWTON_STEPS = NEWTON_STEPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_kind,
    output logic         m_valid,
    input  logic         m_ready,
    input  tlik_status_t status,
    output tlik_cmd_t    cmd
);

    localparam int ITER_W = $clog2(NEWTON_STEPS + 1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_INIT = 5'd1;
    localparam logic [4:0] S_W1   = 5'd2;
    localparam logic [4:0] S_W2   = 5'd3;
    localparam logic [4:0] S_WL   = 5'd4;
    localparam logic [4:0] S_CS   = 5'd5;
    localparam logic [4:0] S_CSD  = 5'd6;
    localparam logic [4:0] S_F0   = 5'd7;
    localparam logic [4:0] S_F1   = 5'd8;
    localparam logic [4:0] S_F2   = 5'd9;
    localparam logic [4:0] S_F3   = 5'd10;
    localparam logic [4:0] S_F4   = 5'd11;
    localparam logic [4:0] S_F5   = 5'd12;
    localparam logic [4:0] S_N0   = 5'd13;
    localparam logic [4:0] S_N1   = 5'd14;
    localparam logic [4:0] S_N2   = 5'd15;
    localparam logic [4:0] S_M0   = 5'd16;
    localparam logic [4:0] S_M1   = 5'd17;
    localparam logic [4:0] S_M2   = 5'd18;
    localparam logic [4:0] S_MST  = 5'd19;
    localparam logic [4:0] S_DI   = 5'd20;
    localparam logic [4:0] S_DS   = 5'd21;
    localparam logic [4:0] S_DD   = 5'd22;
    localparam logic [4:0] S_NEXT = 5'd23;
    localparam logic [4:0] S_SAVE = 5'd24;
    localparam logic [4:0] S_OUT  = 5'd25;

    logic [4:0]        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              sel_reg, sel_next;
    logic              fin_reg, fin_next;
    logic              m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        iter_next   = iter_reg;
        sel_next    = sel_reg;
        fin_next    = fin_reg;
        cmd.op      = OP_NOP;
        cmd.mul_sel = MUL_L1S1;
        cmd.acc_op  = ACC_NONE;
        cmd.idx     = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    fin_next   = s_kind;
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                cmd.op     = OP_INIT_T;
                sel_next   = 1'b0;
                iter_next  = '0;
                state_next = S_W1;
            end
            S_W1: begin
                cmd.op     = OP_WRAP_T1;
                state_next = S_WL;
            end
            S_W2: begin
                cmd.op     = OP_WRAP_SUM;
                state_next = S_WL;
            end
            S_WL: begin
                if (status.wrap_ok) begin
                    cmd.op     = OP_CORDIC_INIT;
                    cnt_next   = '0;
                    state_next = S_CS;
                end else begin
                    cmd.op = OP_WRAP_STEP;
                end
            end
            S_CS: begin
                cmd.op   = OP_CORDIC_STEP;
                cmd.idx  = cnt_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(CORDIC_LAST)) begin
                    state_next = S_CSD;
                end
            end
            S_CSD: begin
                if (!sel_reg) begin
                    cmd.op     = OP_STORE_CS1;
                    sel_next   = 1'b1;
                    state_next = S_W2;
                end else begin
                    cmd.op     = OP_STORE_CS12;
                    sel_next   = 1'b0;
                    state_next = S_F0;
                end
            end
            S_F0: begin
                cmd.mul_sel = MUL_L2C12;
                state_next  = S_F1;
            end
            S_F1: begin
                cmd.mul_sel = MUL_L1C1;
                cmd.acc_op  = ACC_LOAD_RND;
                state_next  = S_F2;
            end
            S_F2: begin
                cmd.mul_sel = MUL_L2S12;
                cmd.acc_op  = ACC_ADD;
                state_next  = S_F3;
            end
            S_F3: begin
                cmd.mul_sel = MUL_L1S1;
                cmd.op      = OP_PX_STORE;
                cmd.acc_op  = ACC_LOAD_RND;
                state_next  = fin_reg ? S_F4 : S_N0;
            end
            S_F4: begin
                cmd.acc_op = ACC_ADD;
                state_next = S_F5;
            end
            S_F5: begin
                cmd.op     = OP_PY_STORE;
                state_next = S_OUT;
            end
            S_N0: begin
                cmd.op      = OP_DEN_STORE;
                cmd.mul_sel = MUL_L2S12;
                state_next  = S_N1;
            end
            S_N1: begin
                cmd.op     = OP_L2S_STORE;
                state_next = S_N2;
            end
            S_N2: begin
                if (status.den_zero) begin
                    cmd.op     = OP_SET_SING;
                    state_next = S_NEXT;
                end else begin
                    cmd.op     = OP_PREP;
                    state_next = S_M0;
                end
            end
            S_M0: begin
                cmd.mul_sel = MUL_LO;
                state_next  = S_M1;
            end
            S_M1: begin
                cmd.mul_sel = MUL_HI;
                cmd.acc_op  = ACC_ADD;
                state_next  = S_M2;
            end
            S_M2: begin
                cmd.acc_op = ACC_ADD_HI;
                state_next = S_MST;
            end
            S_MST: begin
                if (!sel_reg) begin
                    cmd.op     = OP_N0_STORE;
                    sel_next   = 1'b1;
                    state_next = S_M0;
                end else begin
                    cmd.op     = OP_N1_STORE;
                    sel_next   = 1'b0;
                    state_next = S_DI;
                end
            end
            S_DI: begin
                cmd.op     = OP_DIV_INIT;
                cmd.idx    = IDX_W'(sel_reg);
                cnt_next   = IDX_W'(DIV_TOP);
                state_next = S_DS;
            end
            S_DS: begin
                cmd.op   = OP_DIV_STEP;
                cmd.idx  = cnt_reg;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_DD;
                end
            end
            S_DD: begin
                cmd.op  = OP_DIV_DONE;
                cmd.idx = IDX_W'(sel_reg);
                if (!sel_reg) begin
                    sel_next   = 1'b1;
                    state_next = S_DI;
                end else begin
                    sel_next   = 1'b0;
                    state_next = S_NEXT;
                end
            end
            S_NEXT: begin
                if (iter_reg == ITER_W'(NEWTON_STEPS - 1)) begin
                    iter_next  = '0;
                    state_next = S_SAVE;
                end else begin
                    iter_next  = iter_reg + 1'b1;
                    state_next = S_W1;
                end
            end
            S_SAVE: begin
                cmd.op     = OP_SAVE;
                fin_next   = 1'b1;
                state_next = S_INIT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op     = OP_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.op == OP_OUT_LOAD) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            iter_reg    <= '0;
            sel_reg     <= 1'b0;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            iter_reg    <= iter_next;
            sel_reg     <= sel_next;
            fin_reg     <= fin_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== src/two_link_arm_inverse_kinematics_core.sv =====
// Top level of the two-link arm kinematics core; joins tlik_ctrl and tlik_dp. Uses tlik_pkg.
// Solve and load words are handled one word at a time; a singular Newton step skips the
// multiply and divide, and each angle wrap adds a wrap step. The shared 16-step CORDIC
// and the 13-step restoring divider do the arithmetic.
// A finished word waits in the output register while the next word is accepted.
// Synchronous active-low reset clears the configuration registers, the joint angles and the handshakes.
module two_link_arm_inverse_kinematics_core
    import tlik_pkg::*;
#(
    parameter int NEWTON_STEPS = NEWTON_STEPS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_kind,
    input  logic signed [POS_W-1:0]  s_target_x,
    input  logic signed [ANG_W-1:0]  s_target_angle,
    input  logic signed [ANG_W-1:0]  s_load_angle_one,
    input  logic signed [ANG_W-1:0]  s_load_angle_two,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [ANG_W-1:0]  m_angle_one,
    output logic signed [ANG_W-1:0]  m_angle_two,
    output logic signed [POS_W-1:0]  m_tool_x,
    output logic signed [POS_W-1:0]  m_tool_y,
    output logic signed [ANG_W-1:0]  m_tool_angle,
    output logic                     m_singular,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    tlik_cmd_t    cmd;
    tlik_status_t status;

    tlik_ctrl #(
        .NEWTON_STEPS(NEWTON_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tlik_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_kind           (s_kind),
        .s_target_x       (s_target_x),
        .s_target_angle   (s_target_angle),
        .s_load_angle_one (s_load_angle_one),
        .s_load_angle_two (s_load_angle_two),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_angle_one      (m_angle_one),
        .m_angle_two      (m_angle_two),
        .m_tool_x         (m_tool_x),
        .m_tool_y         (m_tool_y),
        .m_tool_angle     (m_tool_angle),
        .m_singular       (m_singular)
    );

endmodule

// ===== sim/two_link_arm_inverse_kinematics_core_tb.sv =====
// Self-checking testbench for the two-link arm kinematics core.
// Drives solve and load words, predicts each result word internally and compares it.
// Depends on tlik_pkg and two_link_arm_inverse_kinematics_core.
`timescale 1ns / 100ps

module two_link_arm_inverse_kinematics_core_tb
    import tlik_pkg::*;
();

    typedef struct {
        logic        kind;
        logic [23:0] tx;
        logic [15:0] tang;
        logic [15:0] la1;
        logic [15:0] la2;
    } arm_cmd_t;

    typedef struct {
        logic [15:0] a1;
        logic [15:0] a2;
        logic [23:0] px;
        logic [23:0] py;
        logic [15:0] phi;
        logic        sing;
    } arm_pose_t;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int N_RANDOM = 630;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_kind = 1'b0;
    logic signed [POS_W-1:0] s_target_x = '0;
    logic signed [ANG_W-1:0] s_target_angle = '0;
    logic signed [ANG_W-1:0] s_load_angle_one = '0;
    logic signed [ANG_W-1:0] s_load_angle_two = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [ANG_W-1:0] m_angle_one;
    logic signed [ANG_W-1:0] m_angle_two;
    logic signed [POS_W-1:0] m_tool_x;
    logic signed [POS_W-1:0] m_tool_y;
    logic signed [ANG_W-1:0] m_tool_angle;
    logic m_singular;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    arm_cmd_t pending_cmds[$];
    arm_pose_t expected_poses[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_send = 1'b0;
    int fail_count = 0;
    int quiet_cycles = 0;

    longint arm_l1, arm_l2, arm_j1off, arm_toff, arm_j2off;
    longint joint1, joint2;

    two_link_arm_inverse_kinematics_core u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, int bits);
        longint hi;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint wrap_angle(longint a);
        longint r;
        r = a % ANG_2PI;
        if (r > ANG_PI) r -= ANG_2PI;
        if (r <= -ANG_PI) r += ANG_2PI;
        return r;
    endfunction

    function automatic void rotate(input longint a, output longint c, output longint s);
        longint z, x, y, nx, at;
        bit flip;
        z = wrap_angle(a) * 8;
        x = CORDIC_GAIN;
        y = 0;
        flip = 1'b0;
        if (z > HALF_PI_Q16) begin
            z -= PI_Q16;
            flip = 1'b1;
        end else if (z < -HALF_PI_Q16) begin
            z += PI_Q16;
            flip = 1'b1;
        end
        for (int i = 0; i < 16; i++) begin
            at = longint'(atan_q16(i[IDX_W-1:0]));
            if (z >= 0) begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z -= at;
            end else begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z += at;
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic void arm_pose(input longint t1, input longint t2,
                                     output longint px, output longint py);
        longint c1, s1, c12, s12;
        rotate(t1, c1, s1);
        rotate(t1 + t2, c12, s12);
        px = floor_shift(arm_l2 * c12 + arm_l1 * c1 + 32768, 16);
        py = floor_shift(arm_l2 * s12 + arm_l1 * s1 + 32768, 16);
    endfunction

    function automatic longint damp_step(longint d);
        if (d > STEP_LIMIT) d = STEP_LIMIT;
        if (d < -STEP_LIMIT) d = -STEP_LIMIT;
        return floor_shift(d * DAMP_Q13 + 4096, 13);
    endfunction

    function automatic arm_pose_t solve_arm(arm_cmd_t c);
        arm_pose_t r;
        longint off2, t1, t2, px, py, tx, tphi;
        longint c1, s1, c12, s12, den, l2s, dx, dphi, n0, n1;
        off2 = arm_toff + arm_j2off;
        r.sing = 1'b0;
        if (c.kind) begin
            joint1 = longint'($signed(c.la1));
            joint2 = longint'($signed(c.la2));
        end else begin
            tx = longint'($signed(c.tx));
            tphi = longint'($signed(c.tang));
            t1 = joint1 + arm_j1off;
            t2 = joint2 + off2;
            for (int i = 0; i < NEWTON_STEPS_DEF; i++) begin
                arm_pose(t1, t2, px, py);
                rotate(t1, c1, s1);
                rotate(t1 + t2, c12, s12);
                den = arm_l1 * s1;
                if (den == 0) begin
                    r.sing = 1'b1;
                    continue;
                end
                l2s = arm_l2 * s12;
                dx = (tx - px) * (64'sd1 <<< 29);
                dphi = tphi - wrap_angle(t1 + t2);
                n0 = -(dx + l2s * dphi);
                n1 = dx + (den + l2s) * dphi;
                t1 += damp_step(n0 / den);
                t2 += damp_step(n1 / den);
            end
            joint1 = clip(t1 - arm_j1off, 16);
            joint2 = clip(t2 - off2, 16);
        end
        t1 = joint1 + arm_j1off;
        t2 = joint2 + off2;
        arm_pose(t1, t2, px, py);
        r.a1 = joint1[15:0];
        r.a2 = joint2[15:0];
        r.px = 24'(clip(px, 24));
        r.py = 24'(clip(py, 24));
        r.phi = 16'(wrap_angle(t1 + t2));
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_cmds.size() > 0 && !hold_send &&
                $urandom_range(99) >= send_idle_pct) begin
                arm_cmd_t c;
                c = pending_cmds.pop_front();
                expected_poses.push_back(solve_arm(c));
                s_valid <= 1'b1;
                s_kind <= c.kind;
                s_target_x <= c.tx;
                s_target_angle <= c.tang;
                s_load_angle_one <= c.la1;
                s_load_angle_two <= c.la2;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                if (expected_poses.size() == 0) begin
                    $error("unexpected result word");
                    fail_count++;
                end else begin
                    arm_pose_t e;
                    e = expected_poses.pop_front();
                    if (m_angle_one !== e.a1) begin
                        $error("angle_one exp %h got %h", e.a1, m_angle_one);
                        fail_count++;
                    end
                    if (m_angle_two !== e.a2) begin
                        $error("angle_two exp %h got %h", e.a2, m_angle_two);
                        fail_count++;
                    end
                    if (m_tool_x !== e.px) begin
                        $error("tool_x exp %h got %h", e.px, m_tool_x);
                        fail_count++;
                    end
                    if (m_tool_y !== e.py) begin
                        $error("tool_y exp %h got %h", e.py, m_tool_y);
                        fail_count++;
                    end
                    if (m_tool_angle !== e.phi) begin
                        $error("tool_angle exp %h got %h", e.phi, m_tool_angle);
                        fail_count++;
                    end
                    if (m_singular !== e.sing) begin
                        $error("singular exp %h got %h", e.sing, m_singular);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_LINK1: arm_l1 = longint'(val);
            CFG_LINK2: arm_l2 = longint'(val);
            CFG_J1OFF: arm_j1off = longint'($signed(val[15:0]));
            CFG_TOFF:  arm_toff = longint'($signed(val[15:0]));
            default:   arm_j2off = longint'($signed(val[15:0]));
        endcase
    endtask

    task automatic drain();
        wait (pending_cmds.size() == 0 && !s_valid && expected_poses.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic setup_arm(logic [22:0] l1, logic [22:0] l2,
                             logic [15:0] o1, logic [15:0] ot, logic [15:0] o2);
        drain();
        write_reg(CFG_LINK1, l1);
        write_reg(CFG_LINK2, l2);
        write_reg(CFG_J1OFF, {7'd0, o1});
        write_reg(CFG_TOFF, {7'd0, ot});
        write_reg(CFG_J2OFF, {7'd0, o2});
    endtask

    function automatic arm_cmd_t make_cmd(logic k, logic [23:0] tx, logic [15:0] ta,
                                          logic [15:0] a1, logic [15:0] a2);
        arm_cmd_t c;
        c.kind = k;
        c.tx = tx;
        c.tang = ta;
        c.la1 = a1;
        c.la2 = a2;
        return c;
    endfunction

    function automatic arm_cmd_t random_cmd();
        logic [15:0] ta;
        ta = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(51000)) - 25500);
        if ($urandom_range(3) == 0) begin
            return make_cmd(1'b1, 24'($urandom), 16'($urandom),
                            ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom), 16'($urandom));
        end
        return make_cmd(1'b0, ($urandom_range(3) == 0) ? 24'($urandom)
                        : 24'($signed($urandom_range(40000)) - 20000),
                        ta, 16'($urandom), 16'($urandom));
    endfunction

    initial begin
        arm_l1 = 0; arm_l2 = 0; arm_j1off = 0; arm_toff = 0; arm_j2off = 0;
        joint1 = 0; joint2 = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero lengths and zero angles make every Newton step singular.
        pending_cmds.push_back(make_cmd(1'b0, 24'h001000, 16'h0400, 16'h0, 16'h0));
        pending_cmds.push_back(make_cmd(1'b1, 24'h0, 16'h0, 16'h0, 16'h0));
        setup_arm(23'd4096, 23'd3000, 16'd0, 16'd0, 16'd0);
        pending_cmds.push_back(make_cmd(1'b0, 24'd5000, 16'd0, 16'h0, 16'h0));
        pending_cmds.push_back(make_cmd(1'b1, 24'hffffff, 16'hffff, 16'h2000, 16'h1000));
        pending_cmds.push_back(make_cmd(1'b0, 24'd5000, 16'd4000, 16'hffff, 16'hffff));
        pending_cmds.push_back(make_cmd(1'b0, 24'h7fffff, 16'h7fff, 16'h0, 16'h0));
        pending_cmds.push_back(make_cmd(1'b0, 24'h800000, 16'h8000, 16'h0, 16'h0));
        pending_cmds.push_back(make_cmd(1'b1, 24'h0, 16'h0, 16'h7fff, 16'h8000));
        pending_cmds.push_back(make_cmd(1'b1, 24'h0, 16'h0, 16'h8000, 16'h7fff));
        pending_cmds.push_back(make_cmd(1'b0, 24'h0, 16'h0, 16'h0, 16'h0));
        setup_arm(23'h7fffff, 23'h7fffff, 16'h7fff, 16'h8000, 16'h7fff);
        pending_cmds.push_back(make_cmd(1'b1, 24'h0, 16'h0, 16'h0, 16'h0));
        pending_cmds.push_back(make_cmd(1'b0, 24'h7fffff, 16'h6000, 16'h0, 16'h0));
        pending_cmds.push_back(make_cmd(1'b0, 24'h800000, 16'ha000, 16'h0, 16'h0));
        pending_cmds.push_back(make_cmd(1'b1, 24'h0, 16'h0, 16'h8000, 16'h8000));
        pending_cmds.push_back(make_cmd(1'b0, 24'h0, 16'h0, 16'h0, 16'h0));

        for (int ph = 0; ph < 6; ph++) begin
            int cnt;
            setup_arm(23'($urandom_range(ph == 5 ? 8388607 : 40000)),
                      23'($urandom_range(ph == 5 ? 8388607 : 40000)),
                      16'($urandom), 16'($urandom), 16'($urandom));
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 69; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 69; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            cnt = N_RANDOM / 6;
            for (int i = 0; i < cnt; i++) begin
                pending_cmds.push_back(random_cmd());
                if (ph == 2 && i == cnt / 2) begin
                    wait (pending_cmds.size() == 0 && !s_valid);
                    hold_send = 1'b1;
                    wait (expected_poses.size() == 0);
                    hold_send = 1'b0;
                end
            end
        end
        drain();
        repeat (400) @(posedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
